// ===== hdl/rlmtf_pkg.sv =====
`default_nettype none

package rlmtf_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_TOUCH = 2'd2;
  localparam logic [1:0] OP_LIST  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/rlmtf_ram.sv =====
`default_nettype none

module rlmtf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/recency_list_move_to_front_core.sv =====
// channel   | handshake                      | payload
// ----------+--------------------------------+---------------------------------------
// command   | start_i, accepted when !busy_o | op_i, key_i
// result    | done_o, one cycle, no stall    | status_o, out_key_o, out_valid_o, last_o
//
// keys live in a single-port-read ram, slot 0 oldest; one compare/move step per cycle
// load/add/touch that hits: search reads slots from slot 0 up to the hit, then shift moves
// the keys above it down one slot and writes the key as newest, then the result register
// touch miss, load append or refusal: search of every slot, then the result register; add of a new key to a non-empty
// window then shifts like a hit at slot 0
// list: results come out on consecutive cycles, last one flagged
// reset clears the state, entry count, read flag and result strobe; slots at or above the count are never read
`default_nettype none

module recency_list_move_to_front_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic [1:0]                            op_i,
  input  wire logic signed [rlmtf_pkg::KEY_W-1:0]    key_i,
  output logic                                       done_o,
  output logic [1:0]                                 status_o,
  output logic signed [rlmtf_pkg::KEY_W-1:0]         out_key_o,
  output logic                                       out_valid_o,
  output logic                                       last_o
);

  localparam int unsigned KW = rlmtf_pkg::KEY_W;
  localparam int unsigned IW = rlmtf_pkg::IDX_W;
  localparam int unsigned CW = rlmtf_pkg::CNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SRCH  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_LIST  = 2'd3;

  // sequencer state
  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;        // keys held
  logic [CW-1:0] idx_q, idx_d;        // next slot to read (search, list, shift source)
  logic          chk_q, chk_d;        // ram data this cycle belongs to a read issued
  logic [IW-1:0] chk_idx_q, chk_idx_d;
  logic [IW-1:0] wr_q, wr_d;          // shift destination
  logic          evict_q, evict_d;

  // captured item and oldest key
  logic [1:0]    op_q, op_d;
  logic [KW-1:0] key_q, key_d;
  logic [KW-1:0] old_q, old_d;

  // result register
  logic          done_q, done_d;
  logic [1:0]    status_q, status_d;
  logic [KW-1:0] okey_q, okey_d;
  logic          oval_q, oval_d;
  logic          last_q, last_d;

  // ram port
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [KW-1:0] wdata, rdata;

  logic          hit;
  logic [CW-1:0] cnt_m1;

  rlmtf_ram #(
    .WIDTH (KW),
    .DEPTH (rlmtf_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign hit    = chk_q && (rdata == key_q);
  assign cnt_m1 = cnt_q - CW'(1);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    chk_d     = 1'b0;
    chk_idx_d = chk_idx_q;
    wr_d      = wr_q;
    evict_d   = evict_q;
    op_d      = op_q;
    key_d     = key_q;
    old_d     = old_q;
    done_d    = 1'b0;
    status_d  = rlmtf_pkg::ST_OK;
    okey_d    = '0;
    oval_d    = 1'b0;
    last_d    = 1'b1;
    we        = 1'b0;
    waddr     = wr_q;
    wdata     = key_q;
    raddr     = idx_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          key_d   = key_i;
          idx_d   = '0;
          evict_d = 1'b0;
          if (op_i == rlmtf_pkg::OP_LIST && cnt_q == '0) begin
            // empty list: single empty result right away
            done_d = 1'b1;
          end else if (op_i == rlmtf_pkg::OP_LIST) begin
            state_d = S_LIST;
          end else begin
            state_d = S_SRCH;
          end
        end
      end

      S_SRCH: begin
        if (chk_q && chk_idx_q == '0) begin
          old_d = rdata;
        end
        if (hit) begin
          // present key: move to newest, same for every op
          state_d = S_SHIFT;
          idx_d   = CW'({1'b0, chk_idx_q} + CW'(1));
          wr_d    = chk_idx_q;
        end else if (idx_q == cnt_q) begin
          if (op_q == rlmtf_pkg::OP_TOUCH) begin
            state_d  = S_IDLE;
            done_d   = 1'b1;
            status_d = rlmtf_pkg::ST_MISS;
          end else if (op_q == rlmtf_pkg::OP_LOAD && cnt_q == CW'(rlmtf_pkg::DEPTH)) begin
            state_d  = S_IDLE;
            done_d   = 1'b1;
            status_d = rlmtf_pkg::ST_FULL;
          end else if (op_q == rlmtf_pkg::OP_LOAD || cnt_q == '0) begin
            // append as newest
            we      = 1'b1;
            waddr   = cnt_q[IW-1:0];
            cnt_d   = cnt_q + CW'(1);
            state_d = S_IDLE;
            done_d  = 1'b1;
          end else begin
            // add of a new key: drop slot 0, shift the rest down
            state_d = S_SHIFT;
            evict_d = 1'b1;
            idx_d   = CW'(1);
            wr_d    = '0;
          end
        end else begin
          chk_d     = 1'b1;
          chk_idx_d = idx_q[IW-1:0];
          idx_d     = idx_q + CW'(1);
        end
      end

      S_SHIFT: begin
        if (idx_q != cnt_q) begin
          chk_d = 1'b1;
          idx_d = idx_q + CW'(1);
        end
        if (chk_q) begin
          we    = 1'b1;
          wdata = rdata;
          wr_d  = wr_q + IW'(1);
        end else if (idx_q == cnt_q) begin
          // newest slot gets the key
          we      = 1'b1;
          waddr   = cnt_m1[IW-1:0];
          state_d = S_IDLE;
          done_d  = 1'b1;
          oval_d  = evict_q;
          okey_d  = evict_q ? old_q : '0;
        end
      end

      S_LIST: begin
        if (idx_q != cnt_q) begin
          chk_d     = 1'b1;
          chk_idx_d = idx_q[IW-1:0];
          idx_d     = idx_q + CW'(1);
        end
        if (chk_q) begin
          done_d = 1'b1;
          okey_d = rdata;
          oval_d = 1'b1;
          last_d = (chk_idx_q == cnt_m1[IW-1:0]);
          if (chk_idx_q == cnt_m1[IW-1:0]) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      chk_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      chk_q   <= chk_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    chk_idx_q <= chk_idx_d;
    wr_q      <= wr_d;
    evict_q   <= evict_d;
    op_q      <= op_d;
    key_q     <= key_d;
    old_q     <= old_d;
    status_q  <= status_d;
    okey_q    <= okey_d;
    oval_q    <= oval_d;
    last_q    <= last_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_key_o   = okey_q;
  assign out_valid_o = oval_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== hdl/rlmtf_checker.sv =====
`default_nettype none

module rlmtf_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                start_i,
  input wire logic                                busy_o,
  input wire logic [1:0]                          op_i,
  input wire logic signed [rlmtf_pkg::KEY_W-1:0]  key_i,
  input wire logic                                done_o,
  input wire logic [1:0]                          status_o,
  input wire logic signed [rlmtf_pkg::KEY_W-1:0]  out_key_o,
  input wire logic                                out_valid_o,
  input wire logic                                last_o
);

  // an accepted item either keeps the block busy or finishes at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || (done_o && last_o))
    else $error("accepted item neither busy nor finished");

  // list results come out back to back up to the last one
  a_list_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |=> done_o)
    else $error("gap inside a multi-result burst");

  // miss and full are single results without a key
  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == rlmtf_pkg::ST_MISS || status_o == rlmtf_pkg::ST_FULL)
    |-> last_o && !out_valid_o)
    else $error("error status on a keyed or non-final result");

  // no key shown unless flagged
  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !out_valid_o |-> out_key_o == '0)
    else $error("key shown without out_valid");

endmodule

bind recency_list_move_to_front_core rlmtf_checker u_rlmtf_checker (.*);

`default_nettype wire

// ===== verif/recency_checker.sv =====
`timescale 1ns / 100ps

module recency_checker
  import rlmtf_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cmd_start_i,
  input  wire logic                     cmd_busy_i,
  input  wire logic [1:0]               cmd_op_i,
  input  wire logic signed [KEY_W-1:0]  cmd_key_i,
  input  wire logic                     res_done_i,
  input  wire logic [1:0]               res_status_i,
  input  wire logic signed [KEY_W-1:0]  res_key_i,
  input  wire logic                     res_valid_i,
  input  wire logic                     res_last_i,
  output int                            mismatch_count_o,
  output int                            due_count_o,
  output int                            checked_count_o
);

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] key;
    logic                    valid;
    logic                    last;
  } window_result_t;

  // shadow of the window, slot 0 oldest
  logic signed [KEY_W-1:0] win_keys [DEPTH];
  int                      win_count;
  window_result_t          due_results [$];

  assign due_count_o = due_results.size();

  function automatic void queue_result(input logic [1:0] status,
                                       input logic signed [KEY_W-1:0] key,
                                       input logic valid, input logic last);
    window_result_t r;
    r.status = status;
    r.key    = key;
    r.valid  = valid;
    r.last   = last;
    due_results.push_back(r);
  endfunction

  function automatic void shift_to_newest(input int pos);
    logic signed [KEY_W-1:0] k;
    k = win_keys[pos];
    for (int i = pos; i + 1 < win_count; i++) win_keys[i] = win_keys[i + 1];
    win_keys[win_count - 1] = k;
  endfunction

  function automatic void apply_window_op(input logic [1:0] op,
                                          input logic signed [KEY_W-1:0] key);
    int                      hit_pos;
    logic signed [KEY_W-1:0] oldest;
    hit_pos = -1;
    if (op == OP_LIST) begin
      if (win_count == 0) begin
        queue_result(ST_OK, '0, 1'b0, 1'b1);
      end else begin
        for (int i = 0; i < win_count; i++)
          queue_result(ST_OK, win_keys[i], 1'b1, i + 1 == win_count);
      end
      return;
    end
    for (int i = 0; i < win_count; i++)
      if (hit_pos < 0 && win_keys[i] == key) hit_pos = i;
    if (hit_pos >= 0) begin
      // present key: any of load, add, touch moves it to newest
      shift_to_newest(hit_pos);
      queue_result(ST_OK, '0, 1'b0, 1'b1);
    end else if (op == OP_TOUCH) begin
      queue_result(ST_MISS, '0, 1'b0, 1'b1);
    end else if (op == OP_LOAD) begin
      if (win_count >= DEPTH) begin
        queue_result(ST_FULL, '0, 1'b0, 1'b1);
      end else begin
        win_keys[win_count] = key;
        win_count++;
        queue_result(ST_OK, '0, 1'b0, 1'b1);
      end
    end else if (win_count == 0) begin
      win_keys[0] = key;
      win_count   = 1;
      queue_result(ST_OK, '0, 1'b0, 1'b1);
    end else begin
      oldest = win_keys[0];
      for (int i = 0; i + 1 < win_count; i++) win_keys[i] = win_keys[i + 1];
      win_keys[win_count - 1] = key;
      queue_result(ST_OK, oldest, 1'b1, 1'b1);
    end
  endfunction

  function automatic void note_mismatch(input string what);
    if (mismatch_count_o < 10) $display("[%0t] mismatch: %s", $time, what);
    mismatch_count_o++;
  endfunction

  initial begin
    win_count        = 0;
    mismatch_count_o = 0;
    checked_count_o  = 0;
  end

  always @(posedge clk_i) begin
    window_result_t want;
    if (rst_ni) begin
      // results first: nothing accepted at this edge can answer at this edge
      if (res_done_i) begin
        checked_count_o++;
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result status=%0d key=%0d valid=%0b last=%0b",
                                  res_status_i, res_key_i, res_valid_i, res_last_i));
        end else begin
          want = due_results.pop_front();
          if (res_status_i !== want.status)
            note_mismatch($sformatf("status expected %0d got %0d", want.status, res_status_i));
          if (res_key_i !== want.key)
            note_mismatch($sformatf("out_key expected %0d got %0d", want.key, res_key_i));
          if (res_valid_i !== want.valid)
            note_mismatch($sformatf("out_valid expected %0b got %0b", want.valid, res_valid_i));
          if (res_last_i !== want.last)
            note_mismatch($sformatf("last expected %0b got %0b", want.last, res_last_i));
        end
      end
      if (cmd_start_i && !cmd_busy_i) apply_window_op(cmd_op_i, cmd_key_i);
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rlmtf_pkg::*;

  localparam int RANDOM_ITEMS = 435;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

  logic                    clk_i   = 1'b0;
  logic                    rst_ni  = 1'b0;
  logic                    start_i = 1'b0;
  logic [1:0]              op_i    = OP_LOAD;
  logic signed [KEY_W-1:0] key_i   = '0;
  logic                    busy_o;
  logic                    done_o;
  logic [1:0]              status_o;
  logic signed [KEY_W-1:0] out_key_o;
  logic                    out_valid_o;
  logic                    last_o;

  int mismatch_count;
  int due_count;
  int checked_count;
  int op_tally [4];
  int quiet_cycles;

  // small pool of keys so that hits, moves and evictions of known keys are common
  logic signed [KEY_W-1:0] key_pool [24];

  always #10 clk_i = ~clk_i;

  recency_list_move_to_front_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .op_i        (op_i),
    .key_i       (key_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .out_key_o   (out_key_o),
    .out_valid_o (out_valid_o),
    .last_o      (last_o)
  );

  recency_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_start_i      (start_i),
    .cmd_busy_i       (busy_o),
    .cmd_op_i         (op_i),
    .cmd_key_i        (key_i),
    .res_done_i       (done_o),
    .res_status_i     (status_o),
    .res_key_i        (out_key_o),
    .res_valid_i      (out_valid_o),
    .res_last_i       (last_o),
    .mismatch_count_o (mismatch_count),
    .due_count_o      (due_count),
    .checked_count_o  (checked_count)
  );

  // watchdog: too long with neither an item taken nor a result strobed
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", due_count);
      $display("status: fail");
      $finish;
    end
  end

  // present an item and hold it until the block takes it
  task automatic issue(input logic [1:0] op, input logic signed [KEY_W-1:0] key);
    start_i <= 1'b1;
    op_i    <= op;
    key_i   <= key;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    op_tally[op]++;
  endtask

  // drop start and scribble on the fields while idle
  task automatic hold_off(input int cycles);
    start_i <= 1'b0;
    op_i    <= 2'($urandom);
    key_i   <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(23)];
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 30) return OP_LOAD;
    if (r < 60) return OP_ADD;
    if (r < 85) return OP_TOUCH;
    return OP_LIST;
  endfunction

  initial begin
    quiet_cycles = 0;
    foreach (op_tally[i]) op_tally[i] = 0;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = '0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < 24; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty window first
    issue(OP_LIST, $urandom);
    issue(OP_TOUCH, 32'sd5);
    // add on an empty window just stores the key
    issue(OP_ADD, 32'sh8000_0000);
    // fill the window with loads, extremes among them
    issue(OP_LOAD, 32'sh7fff_ffff);
    issue(OP_LOAD, '0);
    issue(OP_LOAD, -32'sd1);
    for (int i = 0; i < 12; i++) issue(OP_LOAD, key_pool[4 + i]);
    // window full: new key refused
    issue(OP_LOAD, 32'sh1234_5678);
    // load and add of a present key move it to newest, no duplicate, no eviction
    issue(OP_LOAD, '0);
    issue(OP_ADD, 32'sh7fff_ffff);
    // add of a new key evicts the oldest
    issue(OP_ADD, 32'sh5555_aaaa);
    issue(OP_TOUCH, -32'sd1);
    // touch of the key just evicted misses
    issue(OP_TOUCH, 32'sh8000_0000);
    issue(OP_LIST, $urandom);

    // random part: idle gaps, except for a long back-to-back stretch
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 330) begin
        // let the block drain completely before going on
        hold_off(1);
        while (due_count != 0) @(posedge clk_i);
      end else if ((n < 150 || n >= 260) && $urandom_range(99) < 34) begin
        hold_off($urandom_range(1, 5));
      end
      issue(pick_op(), pick_key());
    end

    hold_off(1);
    while (due_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("items: load %0d, add %0d, touch %0d, list %0d",
             op_tally[OP_LOAD], op_tally[OP_ADD], op_tally[OP_TOUCH], op_tally[OP_LIST]);
    $display("results compared %0d, mismatches %0d, still outstanding %0d",
             checked_count, mismatch_count, due_count);
    if (mismatch_count == 0 && due_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rlmtf_pkg.sv
hdl/rlmtf_ram.sv
hdl/recency_list_move_to_front_core.sv
hdl/rlmtf_checker.sv
verif/recency_checker.sv
verif/tb_top.sv
